FILE: sv/grid_cell_dedup_memory_assert.svh
// Assertion macros for the checker of the grid cell memory.
`ifndef GRID_CELL_DEDUP_MEMORY_ASSERT_SVH
`define GRID_CELL_DEDUP_MEMORY_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define GCD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define GCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: sv/gcdm_pkg.sv
// Package of the grid cell memory: sizes, status codes and register indexes.
`timescale 1ns / 1ps
`default_nettype none
package gcdm_pkg;
   localparam int unsigned MaxEntries = 1024;
   localparam int unsigned CountW = 11;
   localparam int unsigned CsrIdxW = 2;

   typedef enum logic [2:0] {
      ST_STORED    = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_INVALID   = 3'd3,
      ST_LOW_ALT   = 3'd4
   } status_type;

   localparam logic [CsrIdxW-1:0] CSR_RESOLUTION = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_CAPACITY   = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_MIN_ALT    = 2'd2;
endpackage
`default_nettype wire

FILE: sv/grid_cell_dedup_memory.sv
// Top level of the grid cell de-duplicating point memory.
// Each request beat carries one Q16.16 point; it is gated on altitude and finiteness,
// floor-divided by the cell resolution with one shared restoring divider (x then y),
// and its cell key is searched for among the stored keys one entry at a time, each
// read through the key RAM's single port and then compared. The request side is
// stalled while one beat is being worked on; the response register holds the result
// until it is taken and a new request is accepted on the following cycle. The stores
// need no clearing pass: only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none
module grid_cell_dedup_memory #(
   parameter int unsigned MAX_ENTRIES = gcdm_pkg::MaxEntries
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write,
   input  wire logic [gcdm_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [31:0]                   csr_data,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [31:0]            req_point_x,
   input  wire logic signed [31:0]            req_point_y,
   input  wire logic                          req_point_finite,
   input  wire logic signed [31:0]            req_altitude,
   input  wire logic                          req_altitude_ok,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [2:0]                         rsp_status,
   output logic signed [31:0]                 rsp_cell_x,
   output logic signed [31:0]                 rsp_cell_y,
   output logic [10:0]                        rsp_entry_count
);
   localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_SEARCH, S_WAIT, S_DECIDE, S_OUT
   } state_type;

   state_type   state_ff;
   logic [31:0] res_ff;
   logic [10:0] cap_ff;
   logic [30:0] min_alt_ff;
   logic [CW-1:0] count_ff;

   logic [31:0] px_ff, py_ff;
   logic        second_ff;
   logic        neg_ff;
   logic [31:0] mag_ff;      // dividend magnitude, shifts into quotient
   logic [32:0] rem_ff;
   logic [5:0]  step_ff;
   logic [31:0] cx_ff, cy_ff;
   logic [CW-1:0] idx_ff;
   logic        found_ff;

   // Divider step: shift remainder, trial subtract.
   logic [31:0] den;
   logic [32:0] rem_sh, rem_sub;
   logic [31:0] q_bits;
   assign den     = (res_ff == 32'd0) ? 32'd1 : res_ff;
   assign rem_sh  = {rem_ff[31:0], mag_ff[31]};
   assign rem_sub = rem_sh - {1'b0, den};
   assign q_bits  = {mag_ff[30:0], ~rem_sub[32]};

   logic [CW-1:0] limit;
   always_comb begin
      if ({21'd0, cap_ff} < 32'(MAX_ENTRIES)) begin
         limit = CW'(cap_ff);
      end else begin
         limit = CW'(MAX_ENTRIES);
      end
   end

   // Key RAM and point RAM share one address.
   logic [63:0] key_rd, pt_rd;
   logic        ram_we;
   logic [AW-1:0] ram_addr;
   assign ram_we   = (state_ff == S_DECIDE) && !found_ff && (count_ff < limit);
   assign ram_addr = ram_we ? count_ff[AW-1:0] : idx_ff[AW-1:0];

   gcdm_ram #(.WIDTH(64), .DEPTH(1 << AW)) u_key_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data({cx_ff, cy_ff}), .rd_data(key_rd)
   );
   gcdm_ram #(.WIDTH(64), .DEPTH(1 << AW)) u_point_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data({px_ff, py_ff}), .rd_data(pt_rd)
   );

   logic gate_low;
   assign gate_low = (min_alt_ff != 31'd0) &&
      !(req_altitude_ok && ($signed(req_altitude) >= $signed({1'b0, min_alt_ff})));

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         res_ff     <= 32'd65536;
         cap_ff     <= 11'd1024;
         min_alt_ff <= 31'd0;
         count_ff   <= '0;
         rsp_valid  <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               gcdm_pkg::CSR_RESOLUTION: res_ff <= csr_data;
               gcdm_pkg::CSR_CAPACITY:   cap_ff <= csr_data[10:0];
               gcdm_pkg::CSR_MIN_ALT:    min_alt_ff <= csr_data[30:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  px_ff <= req_point_x;
                  py_ff <= req_point_y;
                  rsp_cell_x <= '0;
                  rsp_cell_y <= '0;
                  if (gate_low) begin
                     rsp_status <= gcdm_pkg::ST_LOW_ALT;
                     state_ff   <= S_OUT;
                  end else if (!req_point_finite) begin
                     rsp_status <= gcdm_pkg::ST_INVALID;
                     state_ff   <= S_OUT;
                  end else begin
                     neg_ff    <= req_point_x[31];
                     mag_ff    <= req_point_x[31] ? ~req_point_x : req_point_x;
                     rem_ff    <= '0;
                     step_ff   <= '0;
                     second_ff <= 1'b0;
                     state_ff  <= S_DIV;
                  end
               end
            end
            S_DIV: begin
               // Negative values divide as -x-1 (= ~x) so floor needs no fix-up:
               // floor(x/d) = -(floor((-x-1)/d)) - 1 = ~q.
               if (step_ff != 6'd32) begin
                  mag_ff  <= q_bits;
                  rem_ff  <= rem_sub[32] ? rem_sh : rem_sub;
                  step_ff <= step_ff + 6'd1;
               end else begin
                  if (!second_ff) begin
                     cx_ff     <= neg_ff ? ~mag_ff : mag_ff;
                     second_ff <= 1'b1;
                     neg_ff    <= py_ff[31];
                     mag_ff    <= py_ff[31] ? ~py_ff : py_ff;
                     rem_ff    <= '0;
                     step_ff   <= '0;
                  end else begin
                     cy_ff      <= neg_ff ? ~mag_ff : mag_ff;
                     idx_ff     <= '0;
                     found_ff   <= 1'b0;
                     state_ff   <= S_SEARCH;
                  end
               end
            end
            S_SEARCH: begin
               if (idx_ff >= count_ff) begin
                  state_ff <= S_DECIDE;
               end else begin
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: begin
               if (key_rd == {cx_ff, cy_ff}) begin
                  found_ff <= 1'b1;
                  state_ff <= S_DECIDE;
               end else begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= S_SEARCH;
               end
            end
            S_DECIDE: begin
               rsp_cell_x <= cx_ff;
               rsp_cell_y <= cy_ff;
               if (found_ff) begin
                  rsp_status <= gcdm_pkg::ST_DUPLICATE;
               end else if (count_ff >= limit) begin
                  rsp_status <= gcdm_pkg::ST_FULL;
               end else begin
                  rsp_status <= gcdm_pkg::ST_STORED;
                  count_ff   <= count_ff + CW'(1);
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid) begin
                  rsp_valid <= 1'b1;
               end else if (!rsp_stall) begin
                  rsp_valid <= 1'b0;
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_entry_count = 11'(count_ff);

   // Point RAM is write-only here; its read port is kept for a later reader.
   logic unused_ok;
   assign unused_ok = ^pt_rd;
endmodule
`default_nettype wire

FILE: sv/gcdm_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module gcdm_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

FILE: sv/gcdm_checker.sv
// Port-level checker for the grid cell memory, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_cell_dedup_memory_assert.svh"
module gcdm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_status,
   input wire logic [31:0] rsp_cell_x,
   input wire logic [10:0] rsp_entry_count
);
   // No new request is taken while a result waits.
   `GCD_ASSERT_SAME(a_no_accept_busy, clock, reset, rsp_valid, req_stall)
   // Once a request beat is taken the block stalls the next one.
   `GCD_ASSERT_NEXT(a_accept_stalls, clock, reset, req_valid && !req_stall, req_stall)
   // Only the defined status codes ever appear.
   `GCD_ASSERT_SAME(a_status_range, clock, reset, rsp_valid,
      rsp_status <= gcdm_pkg::ST_LOW_ALT)
   // Gated and invalid results report a zero cell x coordinate.
   `GCD_ASSERT_SAME(a_gated_zero, clock, reset,
      rsp_valid && (rsp_status == gcdm_pkg::ST_INVALID ||
      rsp_status == gcdm_pkg::ST_LOW_ALT), rsp_cell_x == 32'd0)
   // A stalled result holds.
   `GCD_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_status) && $stable(rsp_entry_count))
endmodule

bind grid_cell_dedup_memory gcdm_checker u_gcdm_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
   .rsp_cell_x(rsp_cell_x), .rsp_entry_count(rsp_entry_count)
);
`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench of the grid cell de-duplicating point memory.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   // Clock, reset and the cycle counter that bounds the run.
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   // The limit allows for every beat taking the longest search, plus stalls.
   localparam int unsigned CycleLimit = 6_000_000;
   int unsigned cycle_count = 0;

   // Ports of the block; its inputs are driven to known values from time zero.
   logic              csr_write = 1'b0;
   logic [gcdm_pkg::CsrIdxW-1:0] csr_index = gcdm_pkg::CSR_RESOLUTION;
   logic [31:0]       csr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic              req_point_finite = 1'b0;
   logic signed [31:0] req_altitude = '0;
   logic              req_altitude_ok = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [2:0]        rsp_status;
   logic signed [31:0] rsp_cell_x;
   logic signed [31:0] rsp_cell_y;
   logic [10:0]       rsp_entry_count;

   grid_cell_dedup_memory dut (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .req_valid, .req_stall, .req_point_x, .req_point_y, .req_point_finite,
      .req_altitude, .req_altitude_ok,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_cell_x, .rsp_cell_y, .rsp_entry_count
   );

   // One request beat and one response beat, as the block sees them.
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic               finite;
      logic signed [31:0] alt;
      logic               alt_ok;
   } point_beat_type;

   typedef struct packed {
      gcdm_pkg::status_type status;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic [10:0]        count;
   } cell_result_type;

   // Shadow copy of the registers and the remembered cell keys.
   logic [31:0] shadow_resolution;
   logic [10:0] shadow_capacity;
   logic [30:0] shadow_min_alt;
   logic [63:0] shadow_keys[$];

   cell_result_type pending_results[$];
   int unsigned error_count = 0;
   int unsigned beats_sent = 0;
   int unsigned beats_checked = 0;
   int unsigned stored_seen = 0, dup_seen = 0, full_seen = 0;

   // Knobs shared between the stimulus and the response side.
   bit quiet_phase = 1'b0;      // no idling on either side while set
   bit hold_off_request = 1'b0; // asks the receiver for a long hold-off
   bit hold_active = 1'b0;      // set while the long hold-off runs

   task automatic report_mismatch(input string line);
      $display("mismatch at cycle %0d: %s", cycle_count, line);
      error_count++;
   endtask

   // Floor division of a signed coordinate by the unsigned resolution.
   function automatic logic signed [31:0] floor_cell(input logic signed [31:0] coord,
                                                     input logic [31:0] res);
      longint signed num, den, q;
      num = coord;
      den = (res == 0) ? 64'sd1 : longint'({32'd0, res});
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      return q[31:0];
   endfunction

   // Works out the response of one beat and updates the shadow store.
   function automatic cell_result_type predict_cell(input point_beat_type b);
      cell_result_type r;
      logic [63:0] key;
      int unsigned cap;
      bit found;
      r = '0;
      found = 1'b0;
      if (shadow_min_alt != 0 &&
          !(b.alt_ok && longint'(b.alt) >= longint'({33'd0, shadow_min_alt}))) begin
         r.status = gcdm_pkg::ST_LOW_ALT;
      end else if (!b.finite) begin
         r.status = gcdm_pkg::ST_INVALID;
      end else begin
         r.cx = floor_cell(b.x, shadow_resolution);
         r.cy = floor_cell(b.y, shadow_resolution);
         key = {r.cx, r.cy};
         foreach (shadow_keys[i]) if (shadow_keys[i] == key) found = 1'b1;
         cap = (shadow_capacity < gcdm_pkg::MaxEntries) ? shadow_capacity
                                                         : gcdm_pkg::MaxEntries;
         if (found) r.status = gcdm_pkg::ST_DUPLICATE;
         else if (shadow_keys.size() >= cap) r.status = gcdm_pkg::ST_FULL;
         else begin
            shadow_keys = {shadow_keys, key};
            r.status = gcdm_pkg::ST_STORED;
         end
      end
      r.count = 11'(shadow_keys.size());
      return r;
   endfunction

   task automatic wait_cycles(input int unsigned n);
      repeat (n) @(posedge clock);
   endtask

   // Writes one register; only ever called while the block is idle.
   task automatic write_register(input logic [gcdm_pkg::CsrIdxW-1:0] idx,
                                 input logic [31:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         gcdm_pkg::CSR_RESOLUTION: shadow_resolution = value;
         gcdm_pkg::CSR_CAPACITY:   shadow_capacity = value[10:0];
         gcdm_pkg::CSR_MIN_ALT:    shadow_min_alt = value[30:0];
         default: ;
      endcase
   endtask

   // Waits until every expected response is in, then lets the block return to idle.
   task automatic drain_block();
      while (pending_results.size() != 0) @(posedge clock);
      wait_cycles(8);
   endtask

   // Offers one beat and waits until it is taken; idles before it at random.
   // The prediction is queued at the accepting edge, ahead of the response.
   task automatic send_point(input point_beat_type b);
      if (!quiet_phase && $urandom_range(99) < 29) begin
         @(posedge clock);
         req_valid <= 1'b0;
         wait_cycles($urandom_range(1, 6) - 1);
      end
      @(posedge clock);
      req_valid <= 1'b1;
      req_point_x <= b.x;
      req_point_y <= b.y;
      req_point_finite <= b.finite;
      req_altitude <= b.alt;
      req_altitude_ok <= b.alt_ok;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results = {pending_results, predict_cell(b)};
      beats_sent++;
      // Lowering valid here is safe: this is the same edge that took the beat.
      req_valid <= 1'b0;
   endtask

   // Receiver: idles at random, holds off for a long stretch on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_active) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet_phase && ($urandom_range(99) < 29);
      end
   end

   // Counts out the long hold-off in cycles.
   initial begin
      wait (!reset);
      forever begin
         wait (hold_off_request);
         hold_active = 1'b1;
         wait_cycles(3000);
         hold_active = 1'b0;
         hold_off_request = 1'b0;
      end
   end

   // Response checker: compares each taken beat with the oldest prediction.
   always @(posedge clock) begin
      cell_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response with status %0d while none expected",
                                      rsp_status));
         end else begin
            want = pending_results.pop_front();
            beats_checked++;
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status got %0d expected %0d",
                                         rsp_status, want.status));
            if (rsp_cell_x !== want.cx)
               report_mismatch($sformatf("cell_x got %0h expected %0h",
                                         rsp_cell_x, want.cx));
            if (rsp_cell_y !== want.cy)
               report_mismatch($sformatf("cell_y got %0h expected %0h",
                                         rsp_cell_y, want.cy));
            if (rsp_entry_count !== want.count)
               report_mismatch($sformatf("entry_count got %0d expected %0d",
                                         rsp_entry_count, want.count));
            case (want.status)
               gcdm_pkg::ST_STORED:    stored_seen++;
               gcdm_pkg::ST_DUPLICATE: dup_seen++;
               gcdm_pkg::ST_FULL:      full_seen++;
               default: ;
            endcase
         end
      end
   end

   // Watchdog: a hung block ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d beats outstanding",
                  cycle_count, pending_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Directed table: a beat, and a typed-in response where it is obvious.
   // Register writes ahead of the table: resolution 1.0 m, capacity 4, gate off.
   typedef struct {
      point_beat_type  beat;
      bit              known;
      cell_result_type result;
   } directed_row_type;

   localparam logic signed [31:0] MinS = 32'sh8000_0000;
   localparam logic signed [31:0] MaxS = 32'sh7FFF_FFFF;

   directed_row_type directed_rows[] = '{
      // Non-finite point: skipped, no key.
      '{'{32'sd0, 32'sd0, 1'b0, 32'sd0, 1'b1}, 1'b1,
        '{gcdm_pkg::ST_INVALID, 32'sd0, 32'sd0, 11'd0}},
      // First point at the origin cell is stored.
      '{'{32'sd0, 32'sd0, 1'b1, 32'sd0, 1'b0}, 1'b1,
        '{gcdm_pkg::ST_STORED, 32'sd0, 32'sd0, 11'd1}},
      // Same cell again, lower bits differ: duplicate.
      '{'{32'sh0000_FFFF, 32'sh0000_0001, 1'b1, 32'sd0, 1'b1}, 1'b1,
        '{gcdm_pkg::ST_DUPLICATE, 32'sd0, 32'sd0, 11'd1}},
      // Both extremes and a small negative value; negatives round toward minus infinity.
      '{'{MinS, MinS, 1'b1, MinS, 1'b0}, 1'b0, '{gcdm_pkg::ST_STORED, 0, 0, 0}},
      '{'{MaxS, MaxS, 1'b1, MaxS, 1'b1}, 1'b0, '{gcdm_pkg::ST_STORED, 0, 0, 0}},
      '{'{-32'sd1, 32'sd1, 1'b1, 32'sd0, 1'b1}, 1'b0, '{gcdm_pkg::ST_STORED, 0, 0, 0}},
      // Four cells held: new cell refused, known ones match, non-finite point invalid.
      '{'{32'sh0005_0000, 32'sh0005_0000, 1'b1, 32'sd0, 1'b1}, 1'b1,
        '{gcdm_pkg::ST_FULL, 32'sd5, 32'sd5, 11'd4}},
      '{'{MaxS, MaxS, 1'b1, 32'sd0, 1'b1}, 1'b0, '{gcdm_pkg::ST_STORED, 0, 0, 0}},
      '{'{-32'sd1, 32'sd1, 1'b1, 32'sd0, 1'b0}, 1'b0, '{gcdm_pkg::ST_STORED, 0, 0, 0}},
      '{'{32'sd7, 32'sd0, 1'b0, MaxS, 1'b1}, 1'b1,
        '{gcdm_pkg::ST_INVALID, 32'sd0, 32'sd0, 11'd4}}
   };

   // Second table, run with the altitude gate at 10.0 m and resolution zero.
   // The store is still full with four cells.
   directed_row_type gated_rows[] = '{
      '{'{32'sd3, 32'sd3, 1'b1, 32'sh000A_0000, 1'b0}, 1'b1,
        '{gcdm_pkg::ST_LOW_ALT, 32'sd0, 32'sd0, 11'd4}},
      '{'{32'sd3, 32'sd3, 1'b1, 32'sh0009_FFFF, 1'b1}, 1'b1,
        '{gcdm_pkg::ST_LOW_ALT, 32'sd0, 32'sd0, 11'd4}},
      '{'{32'sd3, 32'sd3, 1'b1, MinS, 1'b1}, 1'b1,
        '{gcdm_pkg::ST_LOW_ALT, 32'sd0, 32'sd0, 11'd4}},
      // Gate passes before finiteness is looked at.
      '{'{32'sd3, 32'sd3, 1'b0, 32'sh000A_0000, 1'b1}, 1'b1,
        '{gcdm_pkg::ST_INVALID, 32'sd0, 32'sd0, 11'd4}},
      '{'{-32'sd3, 32'sd3, 1'b1, MaxS, 1'b1}, 1'b1,
        '{gcdm_pkg::ST_FULL, -32'sd3, 32'sd3, 11'd4}},
      // A remembered cell still reports as a duplicate while the store is full.
      '{'{-32'sd1, 32'sd0, 1'b1, 32'sh000A_0000, 1'b1}, 1'b1,
        '{gcdm_pkg::ST_DUPLICATE, -32'sd1, 32'sd0, 11'd4}}
   };

   task automatic run_rows(input directed_row_type rows[]);
      cell_result_type want;
      foreach (rows[i]) begin
         if (rows[i].known) begin
            // The predictor must agree with the typed-in response too.
            want = rows[i].result;
            send_point(rows[i].beat);
            if (pending_results[$] !== want) begin
               report_mismatch($sformatf("directed row %0d: prediction differs from table",
                                         i));
            end
         end else begin
            send_point(rows[i].beat);
         end
      end
   endtask

   // Random beat: mostly valid points near a few cells so that duplicates occur.
   function automatic point_beat_type random_point(input int unsigned spread);
      point_beat_type b;
      b.x = $urandom_range(99) < 10 ? $urandom() : $signed($urandom_range(2 * spread)) - spread;
      b.y = $urandom_range(99) < 10 ? $urandom() : $signed($urandom_range(2 * spread)) - spread;
      b.finite = $urandom_range(99) < 90;
      b.alt = $urandom_range(99) < 20 ? $urandom() : $signed($urandom_range(32'h0020_0000));
      b.alt_ok = $urandom_range(99) < 90;
      return b;
   endfunction

   task automatic random_phase(input int unsigned beats, input int unsigned spread);
      repeat (beats) send_point(random_point(spread));
   endtask

   initial begin
      shadow_resolution = 32'd65536;
      shadow_capacity = 11'd1024;
      shadow_min_alt = '0;

      wait_cycles(12);
      reset <= 1'b0;

      // Directed checks with a tiny store.
      write_register(gcdm_pkg::CSR_RESOLUTION, 32'd65536);
      write_register(gcdm_pkg::CSR_CAPACITY, 32'd4);
      write_register(gcdm_pkg::CSR_MIN_ALT, 32'd0);
      run_rows(directed_rows);
      drain_block();
      write_register(gcdm_pkg::CSR_RESOLUTION, 32'd0);
      write_register(gcdm_pkg::CSR_MIN_ALT, 32'h000A_0000);
      run_rows(gated_rows);
      drain_block();

      // Random phases across several settings, extremes among them.
      write_register(gcdm_pkg::CSR_CAPACITY, 32'd0);
      write_register(gcdm_pkg::CSR_MIN_ALT, 32'd0);
      write_register(gcdm_pkg::CSR_RESOLUTION, 32'hFFFF_FFFF);
      random_phase(40, 32'h7FFF_0000);
      drain_block();

      write_register(gcdm_pkg::CSR_CAPACITY, 32'd1024);
      write_register(gcdm_pkg::CSR_RESOLUTION, 32'h0004_0000);
      write_register(gcdm_pkg::CSR_MIN_ALT, 32'h0001_0000);
      random_phase(120, 32'h0020_0000);

      // The sender pauses until every response is in, then runs flat out.
      drain_block();
      quiet_phase = 1'b1;
      random_phase(80, 32'h0030_0000);
      quiet_phase = 1'b0;

      // Long receiver hold-off while beats keep being offered.
      hold_off_request = 1'b1;
      random_phase(10, 32'h0030_0000);
      drain_block();

      write_register(gcdm_pkg::CSR_MIN_ALT, 32'h7FFF_FFFF);
      random_phase(30, 32'h0010_0000);
      drain_block();

      write_register(gcdm_pkg::CSR_MIN_ALT, 32'd0);
      write_register(gcdm_pkg::CSR_RESOLUTION, 32'd1);
      write_register(gcdm_pkg::CSR_CAPACITY, 32'd300);
      random_phase(260, 32'd400);
      drain_block();

      $display("beats sent %0d, checked %0d; stored %0d, duplicate %0d, full %0d",
               beats_sent, beats_checked, stored_seen, dup_seen, full_seen);
      $display("covered gating, invalid points, duplicates, full store and stalls");
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: files.f
+incdir+sv
sv/gcdm_pkg.sv
sv/gcdm_ram.sv
sv/grid_cell_dedup_memory.sv
sv/gcdm_checker.sv
verif/tb_top.sv
